@@ hdl/qacs_pkg.sv @@
// shared types, constants and helpers for the quote-aware comment stripper
// no dependencies

package qacs_pkg;

  localparam int CNT_W = 4;          // match counts and run prefix counts
  localparam int QUEUE_DEPTH = 4;
  localparam int CFG_IDX_W = 8;

  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_DELIM  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_LEN    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_DELIM = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_LEN   = 8'd3;

  // quote modes
  localparam logic [1:0] QM_NONE   = 2'd0;
  localparam logic [1:0] QM_DOUBLE = 2'd1;
  localparam logic [1:0] QM_SINGLE = 2'd2;

  typedef struct packed {
    logic [63:0] open_delim;
    logic [3:0]  open_len;
    logic [63:0] close_delim;
    logic [3:0]  close_len;
  } cfg_t;

  // one queued run: prefix_cnt held delimiter bytes, then optionally one literal byte
  typedef struct packed {
    logic [CNT_W-1:0] prefix_cnt;
    logic             has_data;
    logic [7:0]       data;
  } run_t;

  function automatic logic [7:0] delim_byte(input logic [63:0] delim, input logic [2:0] idx);
    delim_byte = delim[{idx, 3'b000} +: 8];
  endfunction

endpackage

@@ hdl/qacs_front.sv @@
// front end: accepts text bytes, tracks comment/quote/match state, builds runs
// depends on qacs_pkg

module qacs_front #(
  parameter int MAX_DELIM_BYTES = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  qacs_pkg::cfg_t cfg,
  input  logic          take,
  input  logic [7:0]    in_byte,
  input  logic          final_byte,
  output logic          push,
  output qacs_pkg::run_t run
);
  import qacs_pkg::*;

  localparam logic [CNT_W-1:0] MAX_LEN = CNT_W'(MAX_DELIM_BYTES);

  logic             comment_active, comment_active_next;
  logic [1:0]       quote_mode, quote_mode_next;
  logic [CNT_W-1:0] match_count, match_count_next;
  logic [7:0]       prev_byte;

  logic [CNT_W-1:0] olen, clen, mc_eff, mc_inc;
  logic [7:0]       quote_ch;
  logic             emits;

  function automatic logic [CNT_W-1:0] eff_len(input logic [3:0] len);
    if (len == 4'd0) eff_len = CNT_W'(1);
    else if (len > MAX_LEN) eff_len = MAX_LEN;
    else eff_len = len;
  endfunction

  always_comb begin
    olen = eff_len(cfg.open_len);
    clen = eff_len(cfg.close_len);
    comment_active_next = comment_active;
    quote_mode_next = quote_mode;
    match_count_next = match_count;
    run.prefix_cnt = '0;
    run.has_data = 1'b0;
    run.data = in_byte;
    quote_ch = (quote_mode == QM_DOUBLE) ? CH_DQUOTE : CH_SQUOTE;
    mc_eff = match_count;
    mc_inc = match_count + CNT_W'(1);

    if (comment_active) begin
      // stale count after a length change starts over
      mc_eff = (match_count >= clen) ? '0 : match_count;
      mc_inc = mc_eff + CNT_W'(1);
      if (in_byte != delim_byte(cfg.close_delim, mc_eff[2:0])) begin
        match_count_next = '0;
      end else if (mc_inc == clen) begin
        comment_active_next = 1'b0;
        match_count_next = '0;
        if (delim_byte(cfg.close_delim, 3'd0) == CH_NL) begin
          run.has_data = 1'b1;
          run.data = CH_NL;
        end
      end else begin
        match_count_next = mc_inc;
      end
    end else if (quote_mode == QM_DOUBLE || quote_mode == QM_SINGLE) begin
      match_count_next = '0;
      run.has_data = 1'b1;
      if (in_byte == quote_ch && prev_byte != CH_BSLASH) quote_mode_next = QM_NONE;
    end else begin
      quote_mode_next = QM_NONE;
      mc_eff = (match_count >= olen) ? '0 : match_count;
      mc_inc = mc_eff + CNT_W'(1);
      if (in_byte != delim_byte(cfg.open_delim, mc_eff[2:0])) begin
        // release the held prefix, then the byte itself
        run.prefix_cnt = mc_eff;
        run.has_data = 1'b1;
        match_count_next = '0;
        if (in_byte == CH_DQUOTE) quote_mode_next = QM_DOUBLE;
        else if (in_byte == CH_SQUOTE) quote_mode_next = QM_SINGLE;
      end else if (mc_inc == olen) begin
        comment_active_next = 1'b1;
        match_count_next = '0;
      end else begin
        match_count_next = mc_inc;
      end
    end

    // end of stream flushes a partial open match
    if (final_byte && !comment_active_next && match_count_next != '0) begin
      run.prefix_cnt = match_count_next;
      match_count_next = '0;
    end

    emits = run.has_data || (run.prefix_cnt != '0);
    push = take && emits;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      comment_active <= 1'b0;
      quote_mode <= QM_NONE;
      match_count <= '0;
      prev_byte <= '0;
    end else if (take) begin
      comment_active <= comment_active_next;
      quote_mode <= quote_mode_next;
      match_count <= match_count_next;
      prev_byte <= in_byte;
    end
  end

  a_count_below_max: assert property (@(posedge clk) disable iff (rst)
    match_count < MAX_LEN) else $error("match count reached delimiter maximum");

  a_comment_no_quote: assert property (@(posedge clk) disable iff (rst)
    comment_active |-> quote_mode == QM_NONE) else $error("quote mode set inside comment");

  a_prefix_fits: assert property (@(posedge clk) disable iff (rst)
    push |-> run.prefix_cnt < MAX_LEN) else $error("held prefix too long");

endmodule

@@ hdl/qacs_fifo.sv @@
// short run queue between front and back
// depends on qacs_pkg

module qacs_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  qacs_pkg::run_t push_run,
  input  logic           pop,
  output qacs_pkg::run_t head,
  output logic           empty,
  output logic           full
);
  import qacs_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  run_t              mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  rd_ptr, wr_ptr;
  logic [CNT_QW-1:0] count;

  assign empty = (count == '0);
  assign full = (count == CNT_QW'(QUEUE_DEPTH));
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      if (push && !pop) count <= count + CNT_QW'(1);
      else if (pop && !push) count <= count - CNT_QW'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop) && !(pop && empty)) else $error("queue over/underflow");

endmodule

@@ hdl/qacs_back.sv @@
// back end: expands queued runs into output bytes, one per transaction
// depends on qacs_pkg

module qacs_back (
  input  logic           clk,
  input  logic           rst,
  input  logic [63:0]    open_delim,
  input  qacs_pkg::run_t head,
  input  logic           empty,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_byte,
  output logic           run_end
);
  import qacs_pkg::*;

  logic [CNT_W-1:0] pos;
  logic [CNT_W:0]   total;
  logic             xfer;

  always_comb begin
    total = {1'b0, head.prefix_cnt} + {{CNT_W{1'b0}}, head.has_data};
    out_valid = !empty;
    run_end = ({1'b0, pos} + (CNT_W+1)'(1)) == total;
    out_byte = (pos < head.prefix_cnt) ? delim_byte(open_delim, pos[2:0]) : head.data;
    xfer = out_valid && !out_stall;
    pop = xfer && run_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (xfer) begin
      pos <= run_end ? '0 : pos + CNT_W'(1);
    end
  end

endmodule

@@ hdl/quote_aware_comment_stripper.sv @@
// top level of the quote-aware comment stripper: config registers, front, queue, back
// depends on qacs_pkg, qacs_front, qacs_fifo, qacs_back

// Takes one source byte per transaction and drops comments framed by the open
// and close delimiters (1 to 8 bytes each, set through the config port), while
// double- and single-quoted strings pass untouched (a backslash before the
// closing quote keeps the string open). The front end accepts a byte every
// cycle as long as the 4-entry run queue has room; each byte that produces
// output queues one run. The back end sends one output byte per cycle while
// out_stall is low. Each input byte yields usually one output byte or none,
// up to eight when a held partial open delimiter is released, and in_stall
// only rises when the queue fills behind a slow or stalled output side. The
// last byte of every run carries run_end. The user must write config only
// while idle; the block itself does not enforce it. cfg_ready is always high.

module quote_aware_comment_stripper #(
  parameter int MAX_DELIM_BYTES = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  // input stream
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_byte,
  input  logic                          final_byte,
  // output stream
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_byte,
  output logic                          run_end,
  // config writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [qacs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_data
);
  import qacs_pkg::*;

  cfg_t cfg;
  logic take, push, pop, empty, full;
  run_t push_run, head;

  // config registers, writes always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.open_delim <= 64'h2A2F;
      cfg.open_len <= 4'd2;
      cfg.close_delim <= 64'h2F2A;
      cfg.close_len <= 4'd2;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_OPEN_DELIM:  cfg.open_delim <= cfg_data;
        REG_OPEN_LEN:    cfg.open_len <= cfg_data[3:0];
        REG_CLOSE_DELIM: cfg.close_delim <= cfg_data;
        REG_CLOSE_LEN:   cfg.close_len <= cfg_data[3:0];
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  // input side stalls only on a full queue
  assign in_stall = full;
  assign take = in_valid && !in_stall;

  qacs_front #(
    .MAX_DELIM_BYTES(MAX_DELIM_BYTES)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .take(take),
    .in_byte(in_byte),
    .final_byte(final_byte),
    .push(push),
    .run(push_run)
  );

  qacs_fifo u_fifo (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_run(push_run),
    .pop(pop),
    .head(head),
    .empty(empty),
    .full(full)
  );

  // prefix bytes read live open_delim, unlatched; user keeps it stable while busy
  qacs_back u_back (
    .clk(clk),
    .rst(rst),
    .open_delim(cfg.open_delim),
    .head(head),
    .empty(empty),
    .pop(pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte(out_byte),
    .run_end(run_end)
  );

endmodule
